// ----- design/source_line_classifier_macros.svh -----
// assertion helpers for the source line classifier
`ifndef SOURCE_LINE_CLASSIFIER_MACROS_SVH
`define SOURCE_LINE_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define SLC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("source_line_classifier: assertion failed");

// next-cycle implication, disabled during reset
`define SLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("source_line_classifier: assertion failed");

`else

`define SLC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- design/slc_pkg.sv -----
`timescale 1ns / 1ps

package slc_pkg;

  // characters that steer the scan
  localparam logic [15:0] CH_SLASH = 16'h002F;
  localparam logic [15:0] CH_STAR  = 16'h002A;
  localparam logic [15:0] CH_NL    = 16'h000A;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_CR    = 16'h000D;

  // scan mode
  typedef enum logic [1:0] {
    MODE_CODE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_BLOCK = 2'd2
  } mode_t;

  // character waiting for its lookahead
  typedef enum logic [1:0] {
    MARK_NONE  = 2'd0,
    MARK_SLASH = 2'd1,
    MARK_STAR  = 2'd2
  } mark_t;

  // kind of a closed line
  typedef enum logic [1:0] {
    CLS_CODE    = 2'd0,
    CLS_MIXED   = 2'd1,
    CLS_COMMENT = 2'd2,
    CLS_BLANK   = 2'd3
  } class_t;

endpackage

// ----- design/source_line_classifier.sv -----
`timescale 1ns / 1ps
// source_line_classifier
// Counts the lines of a C/C++ source text by kind: code, code with comment,
// comment only, blank. The text enters one 16-bit character per transfer on
// the in_ channel (in_valid / in_stall); in_last_char marks the final one.
// Every accepted character yields exactly one result on the out_ channel
// (out_valid / out_stall): line_done and line_class tell whether that
// character closed a line and of which kind, the four counts give the
// running totals (saturating at 2^COUNT_WIDTH-1), and text_done flags the
// result of the final character.
// From input transfer to result the path is one input register, then the
// scan update and the result register. Throughput is one character per
// cycle while the receiver does not stall.
// Counts keep accumulating across texts; the scan state returns to code
// mode after each final character. Reset (rst_n low, synchronous) clears
// the scan state, the counters and both pipeline valids.
// When the receiver stalls, the result holds; one more character can wait
// in the input register, after which in_stall rises.
module source_line_classifier #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [15:0]            in_char_code,
  input  logic                   in_last_char,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_line_done,
  output logic [1:0]             out_line_class,
  output logic [COUNT_WIDTH-1:0] out_code_count,
  output logic [COUNT_WIDTH-1:0] out_mixed_count,
  output logic [COUNT_WIDTH-1:0] out_comment_count,
  output logic [COUNT_WIDTH-1:0] out_blank_count,
  output logic                   out_text_done
);

  import slc_pkg::*;
  `include "source_line_classifier_macros.svh"

  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  // input register
  logic        s1_valid_r;
  logic [15:0] s1_char_r;
  logic        s1_last_r;

  // scan state
  mode_t mode_r, mode_nxt;
  mark_t mark_r, mark_nxt;
  logic  has_code_r, has_code_nxt;
  logic  has_cmt_r, has_cmt_nxt;
  logic [COUNT_WIDTH-1:0] code_r, code_nxt;
  logic [COUNT_WIDTH-1:0] mixed_r, mixed_nxt;
  logic [COUNT_WIDTH-1:0] cmt_r, cmt_nxt;
  logic [COUNT_WIDTH-1:0] blank_r, blank_nxt;

  // result register
  logic   out_valid_r;
  logic   done_r, done_nxt;
  class_t cls_r, cls_nxt;
  logic   text_done_r;

  logic advance;

  // stage 1 moves on when the result register is free or being taken
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  // input register and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last_char;
    end
  end

  // scan update for the character in the input register
  always_comb begin
    logic   consumed;
    logic   close;
    logic   blank;
    class_t cls;
    consumed     = 1'b0;
    close        = 1'b0;
    cls          = CLS_CODE;
    mode_nxt     = mode_r;
    mark_nxt     = MARK_NONE;
    has_code_nxt = has_code_r;
    has_cmt_nxt  = has_cmt_r;
    code_nxt     = code_r;
    mixed_nxt    = mixed_r;
    cmt_nxt      = cmt_r;
    blank_nxt    = blank_r;
    done_nxt     = 1'b0;
    cls_nxt      = CLS_CODE;
    blank = (s1_char_r == CH_SPACE) || (s1_char_r == CH_TAB) || (s1_char_r == CH_CR);

    // resolve the pending mark against this character
    case (mark_r)
      MARK_SLASH: begin
        if (s1_char_r == CH_STAR) begin
          mode_nxt    = MODE_BLOCK;
          has_cmt_nxt = 1'b1;
          consumed    = 1'b1;
        end else if (s1_char_r == CH_SLASH) begin
          mode_nxt    = MODE_LINE;
          has_cmt_nxt = 1'b1;
          consumed    = 1'b1;
        end else begin
          has_code_nxt = 1'b1;
        end
      end
      MARK_STAR: begin
        if (s1_char_r == CH_SLASH) begin
          mode_nxt    = MODE_CODE;
          has_cmt_nxt = 1'b1;
          consumed    = 1'b1;
        end
      end
      default: ;
    endcase

    // ordinary handling
    if (!consumed) begin
      if (s1_char_r == CH_NL) begin
        close = 1'b1;
        if (mode_nxt == MODE_LINE) begin
          mode_nxt = MODE_CODE;
        end
      end else begin
        case (mode_nxt)
          MODE_CODE: begin
            if (s1_char_r == CH_SLASH) begin
              mark_nxt = MARK_SLASH;
            end else if (!blank) begin
              has_code_nxt = 1'b1;
            end
          end
          MODE_BLOCK: begin
            if (s1_char_r == CH_STAR) begin
              has_cmt_nxt = 1'b1;
              mark_nxt    = MARK_STAR;
            end else if (!blank) begin
              has_cmt_nxt = 1'b1;
            end
          end
          MODE_LINE: ;
          default: mode_nxt = MODE_CODE;
        endcase
      end
    end

    // unterminated last line
    if (s1_last_r && !close) begin
      if (mark_nxt == MARK_SLASH) begin
        has_code_nxt = 1'b1;
      end
      close = 1'b1;
    end

    // classify and count the closed line
    if (close) begin
      if (has_code_nxt && has_cmt_nxt) begin
        cls = CLS_MIXED;
        if (mixed_r != CntMax) mixed_nxt = mixed_r + 1'b1;
      end else if (has_cmt_nxt) begin
        cls = CLS_COMMENT;
        if (cmt_r != CntMax) cmt_nxt = cmt_r + 1'b1;
      end else if (has_code_nxt) begin
        cls = CLS_CODE;
        if (code_r != CntMax) code_nxt = code_r + 1'b1;
      end else begin
        cls = CLS_BLANK;
        if (blank_r != CntMax) blank_nxt = blank_r + 1'b1;
      end
      has_code_nxt = 1'b0;
      has_cmt_nxt  = 1'b0;
      done_nxt     = 1'b1;
      cls_nxt      = cls;
    end

    // end of text returns the scan to its start
    if (s1_last_r) begin
      mode_nxt     = MODE_CODE;
      mark_nxt     = MARK_NONE;
      has_code_nxt = 1'b0;
      has_cmt_nxt  = 1'b0;
    end
  end

  // scan state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_CODE;
      mark_r     <= MARK_NONE;
      has_code_r <= 1'b0;
      has_cmt_r  <= 1'b0;
      code_r     <= '0;
      mixed_r    <= '0;
      cmt_r      <= '0;
      blank_r    <= '0;
    end else if (advance) begin
      mode_r     <= mode_nxt;
      mark_r     <= mark_nxt;
      has_code_r <= has_code_nxt;
      has_cmt_r  <= has_cmt_nxt;
      code_r     <= code_nxt;
      mixed_r    <= mixed_nxt;
      cmt_r      <= cmt_nxt;
      blank_r    <= blank_nxt;
    end
  end

  // result register; counts change only when a new result loads
  always_ff @(posedge clk) begin
    if (advance) begin
      done_r      <= done_nxt;
      cls_r       <= cls_nxt;
      text_done_r <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_done     = done_r;
  assign out_line_class    = cls_r;
  assign out_code_count    = code_r;
  assign out_mixed_count   = mixed_r;
  assign out_comment_count = cmt_r;
  assign out_blank_count   = blank_r;
  assign out_text_done     = text_done_r;

  // checks
  `SLC_ASSERT_NOW(a_final_closes, clk, rst_n, out_valid_r && text_done_r, done_r)
  `SLC_ASSERT_NOW(a_class_idle, clk, rst_n, out_valid_r && !done_r, cls_r == CLS_CODE)
  `SLC_ASSERT_NEXT(a_text_end_clears, clk, rst_n, advance && s1_last_r, mode_r == MODE_CODE && mark_r == MARK_NONE && !has_code_r && !has_cmt_r)
  `SLC_ASSERT_NEXT(a_code_monotonic, clk, rst_n, 1'b1, code_r >= $past(code_r) && blank_r >= $past(blank_r))
  `SLC_ASSERT_NOW(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r && out_valid_r)

endmodule
